// File: design/lzrd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzrd_pkg
// Types, codes and sizes shared by the LZSS/RLE stream decompressor.
// ----------------------------------------------------------------------------
package lzrd_pkg;

    // History window. The depth must be a power of two of at least 4096.
    localparam int WINDOW_DEPTH = 4096;
    localparam int WIN_AW       = $clog2(WINDOW_DEPTH);

    // Width of the target length register; the output count is one bit wider.
    localparam int LENGTH_WIDTH = 24;
    localparam int COUNT_W      = LENGTH_WIDTH + 1;

    localparam int OFFSET_W  = 12;
    localparam int REPEAT_W  = 9;
    localparam int CFG_IDX_W = 2;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_RUN_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET   = 2'd1;

    // Result status codes.
    localparam logic [1:0] ST_RUNNING = 2'd0;
    localparam logic [1:0] ST_DONE    = 2'd1;
    localparam logic [1:0] ST_ERROR   = 2'd2;

    // Token phase codes.
    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_FIRST   = 2'd1;
    localparam logic [1:0] PH_LONG    = 2'd2;
    localparam logic [1:0] PH_FLAGGED = 2'd3;

    // Token constants.
    localparam logic [7:0] FLAG_MARK     = 8'h80;
    localparam logic [3:0] RUN_NIBBLE    = 4'hf;
    localparam int         TOKEN_MIN_LEN = 3;
    localparam int         LONG_RUN_BASE = 19;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0]          out_byte;
        logic [REPEAT_W-1:0] out_repeat;
        logic                out_last;
        logic [1:0]          status;
    } out_item_t;

    typedef struct packed {
        logic                    run_mode_enable;
        logic [LENGTH_WIDTH-1:0] target_length;
    } cfg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEC,
        S_RUN,
        S_RD,
        S_CP,
        S_END
    } seq_state_t;

endpackage

// File: design/lzss_rle_stream_decompressor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzss_rle_stream_decompressor_top
// LZSS stream decompressor with run-length tokens: configuration registers,
// the history RAM, the token sequencer and the result output register.
// ----------------------------------------------------------------------------
// A literal goes from byte_reg through S_DEC and S_END to the output register;
// S_END waits while it is full; no new byte is taken until the return to S_IDLE.
// Copies read each byte from the history (S_RD), then write it (S_CP); a run
// stays in S_RUN, as the single history write port stores every repeated byte.
// Reset: rst_n clears the control state and configuration; the history is not
// cleared, and no clearing pass runs.
module lzss_rle_stream_decompressor_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  lzrd_pkg::in_item_t                in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output lzrd_pkg::out_item_t               out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lzrd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lzrd_pkg::LENGTH_WIDTH-1:0] cfg_data
);

    import lzrd_pkg::*;

    cfg_t        cfg_reg;
    logic        out_valid_reg;
    out_item_t   out_data_reg;
    logic        out_free;
    logic        res_valid;
    out_item_t   res_data;
    logic              ram_wr_en;
    logic [WIN_AW-1:0] ram_wr_addr;
    logic [7:0]        ram_wr_data;
    logic              ram_rd_en;
    logic [WIN_AW-1:0] ram_rd_addr;
    logic [7:0]        ram_rd_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_RUN_MODE: cfg_reg.run_mode_enable <= cfg_data[0];
                REG_TARGET:   cfg_reg.target_length   <= cfg_data;
                default:      cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // The output register frees up in the same cycle as its transfer.
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_data_reg <= res_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    lzrd_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_DEPTH)
    ) u_history (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    lzrd_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_free    (out_free),
        .res_valid   (res_valid),
        .res_data    (res_data),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

endmodule

// File: design/lzrd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzrd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lzrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/lzrd_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzrd_seq
// Token sequencer: decodes one compressed byte, then drives the shared
// history write and output count unit one byte per step for literals,
// runs and back-reference copies.
// ----------------------------------------------------------------------------
module lzrd_seq (
    input  logic                       clk,
    input  logic                       rst_n,
    input  lzrd_pkg::cfg_t             cfg,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  lzrd_pkg::in_item_t         in_data,
    input  logic                       out_free,
    output logic                       res_valid,
    output lzrd_pkg::out_item_t        res_data,
    output logic                       ram_wr_en,
    output logic [lzrd_pkg::WIN_AW-1:0] ram_wr_addr,
    output logic [7:0]                 ram_wr_data,
    output logic                       ram_rd_en,
    output logic [lzrd_pkg::WIN_AW-1:0] ram_rd_addr,
    input  logic [7:0]                 ram_rd_data
);

    import lzrd_pkg::*;

    typedef enum logic [1:0] {
        ACT_END,
        ACT_RUN,
        ACT_COPY
    } act_t;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    seq_state_t state_reg, state_next;

    logic [1:0]          phase_reg, phase_next;
    logic [7:0]          flag_reg, flag_next;
    logic [7:0]          ftb_reg, ftb_next;
    logic [1:0]          finish_reg, finish_next;
    logic [COUNT_W-1:0]  cnt_reg, cnt_next;
    logic [7:0]          byte_reg, byte_next;
    logic                last_reg, last_next;
    logic [7:0]          val_reg, val_next;
    logic [REPEAT_W-1:0] rep_reg, rep_next;
    logic [REPEAT_W-1:0] rem_reg, rem_next;
    logic [OFFSET_W-1:0] off_reg, off_next;
    logic                have_reg, have_next;

    logic [COUNT_W-1:0]  cnt_inc;
    logic                cnt_ge_target;
    logic                pre_done;
    logic                rem_one;
    logic [1:0]          end_fin;
    logic                end_emit;
    logic                end_go;
    logic                start_tok;
    logic                start_lit;
    logic [OFFSET_W-1:0] dec_off;
    act_t                act;

    // Shared count unit: saturating increment and the target compare.
    assign cnt_inc       = (cnt_reg == COUNT_MAX) ? cnt_reg : cnt_reg + COUNT_W'(1);
    assign cnt_ge_target = cnt_reg >= {1'b0, cfg.target_length};
    assign pre_done      = (finish_reg == ST_RUNNING) && (phase_reg == PH_IDLE)
                           && cnt_ge_target;
    assign rem_one       = (rem_reg == REPEAT_W'(1));
    assign dec_off       = {byte_reg[3:0], ftb_reg};

    always_comb
    begin
        if (finish_reg != ST_RUNNING)
        begin
            end_fin = finish_reg;
        end
        else if ((phase_reg == PH_IDLE) && cnt_ge_target)
        begin
            end_fin = ST_DONE;
        end
        else if (last_reg)
        begin
            end_fin = ST_ERROR;
        end
        else
        begin
            end_fin = ST_RUNNING;
        end
    end

    assign end_emit = have_reg || (end_fin != ST_RUNNING);
    assign end_go   = !end_emit || out_free;

    // Datapath and history port.
    always_comb
    begin
        phase_next  = phase_reg;
        flag_next   = flag_reg;
        ftb_next    = ftb_reg;
        finish_next = finish_reg;
        cnt_next    = cnt_reg;
        byte_next   = byte_reg;
        last_next   = last_reg;
        val_next    = val_reg;
        rep_next    = rep_reg;
        rem_next    = rem_reg;
        off_next    = off_reg;
        have_next   = have_reg;
        ram_wr_en   = 1'b0;
        ram_wr_data = val_reg;
        ram_rd_en   = 1'b0;
        ram_rd_addr = cnt_reg[WIN_AW-1:0] - WIN_AW'(off_reg);
        start_tok   = 1'b0;
        start_lit   = 1'b0;
        act         = ACT_END;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    byte_next = in_data.in_byte;
                    last_next = in_data.in_last;
                    have_next = 1'b0;
                end
            end
            S_DEC:
            begin
                if (pre_done)
                begin
                    finish_next = ST_DONE;
                end
                if ((finish_reg == ST_RUNNING) && !pre_done)
                begin
                    unique case (phase_reg)
                        PH_IDLE:
                        begin
                            if (flag_reg[7:1] == 7'd0)
                            begin
                                // A new flag byte; its first flag is handled next.
                                flag_next  = FLAG_MARK | {1'b0, byte_reg[7:1]};
                                ftb_next   = byte_reg;
                                phase_next = PH_FLAGGED;
                            end
                            else
                            begin
                                flag_next = {1'b0, flag_reg[7:1]};
                                start_tok = 1'b1;
                                start_lit = flag_reg[0];
                            end
                        end
                        PH_FLAGGED:
                        begin
                            start_tok = 1'b1;
                            start_lit = ftb_reg[0];
                        end
                        PH_FIRST:
                        begin
                            if (cfg.run_mode_enable && (byte_reg[7:4] == RUN_NIBBLE))
                            begin
                                if (byte_reg[3:0] == 4'd0)
                                begin
                                    phase_next = PH_LONG;
                                end
                                else
                                begin
                                    val_next   = ftb_reg;
                                    rem_next   = REPEAT_W'(byte_reg[3:0])
                                                 + REPEAT_W'(TOKEN_MIN_LEN);
                                    rep_next   = rem_next;
                                    phase_next = PH_IDLE;
                                    act        = ACT_RUN;
                                end
                            end
                            else
                            begin
                                off_next   = dec_off;
                                rem_next   = REPEAT_W'(byte_reg[7:4])
                                             + REPEAT_W'(TOKEN_MIN_LEN);
                                phase_next = PH_IDLE;
                                if ((dec_off == '0) || (cnt_reg < COUNT_W'(dec_off)))
                                begin
                                    finish_next = ST_ERROR;
                                end
                                else
                                begin
                                    act = ACT_COPY;
                                end
                            end
                        end
                        PH_LONG:
                        begin
                            val_next   = byte_reg;
                            rem_next   = REPEAT_W'(ftb_reg) + REPEAT_W'(LONG_RUN_BASE);
                            rep_next   = rem_next;
                            phase_next = PH_IDLE;
                            act        = ACT_RUN;
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
                if (start_tok)
                begin
                    if (start_lit)
                    begin
                        ram_wr_en   = 1'b1;
                        ram_wr_data = byte_reg;
                        cnt_next    = cnt_inc;
                        val_next    = byte_reg;
                        rep_next    = REPEAT_W'(1);
                        have_next   = 1'b1;
                        phase_next  = PH_IDLE;
                    end
                    else
                    begin
                        ftb_next   = byte_reg;
                        phase_next = PH_FIRST;
                    end
                end
            end
            S_RUN:
            begin
                ram_wr_en = 1'b1;
                cnt_next  = cnt_inc;
                rem_next  = rem_reg - REPEAT_W'(1);
                if (rem_one)
                begin
                    have_next = 1'b1;
                end
            end
            S_RD:
            begin
                ram_rd_en = 1'b1;
            end
            S_CP:
            begin
                ram_wr_data = ram_rd_data;
                if (rem_one)
                begin
                    // The last copied byte is held back to carry the status.
                    ram_wr_en = 1'b1;
                    cnt_next  = cnt_inc;
                    val_next  = ram_rd_data;
                    rep_next  = REPEAT_W'(1);
                    have_next = 1'b1;
                    rem_next  = rem_reg - REPEAT_W'(1);
                end
                else if (out_free)
                begin
                    ram_wr_en = 1'b1;
                    cnt_next  = cnt_inc;
                    rem_next  = rem_reg - REPEAT_W'(1);
                end
            end
            S_END:
            begin
                if (end_go)
                begin
                    finish_next = end_fin;
                end
            end
            default:
            begin
                have_next = 1'b0;
            end
        endcase
    end

    assign ram_wr_addr = cnt_reg[WIN_AW-1:0];

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                unique case (act)
                    ACT_RUN:  state_next = S_RUN;
                    ACT_COPY: state_next = S_RD;
                    default:  state_next = S_END;
                endcase
            end
            S_RUN:
            begin
                if (rem_one)
                begin
                    state_next = S_END;
                end
            end
            S_RD:
            begin
                state_next = S_CP;
            end
            S_CP:
            begin
                if (rem_one)
                begin
                    state_next = S_END;
                end
                else if (out_free)
                begin
                    state_next = S_RD;
                end
            end
            S_END:
            begin
                if (end_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        in_stall  = (state_reg != S_IDLE);
        res_valid = 1'b0;
        res_data  = '0;
        unique case (state_reg)
            S_CP:
            begin
                if (!rem_one && out_free)
                begin
                    res_valid           = 1'b1;
                    res_data.out_byte   = ram_rd_data;
                    res_data.out_repeat = REPEAT_W'(1);
                    res_data.out_last   = 1'b0;
                    res_data.status     = ST_RUNNING;
                end
            end
            S_END:
            begin
                if (end_emit && out_free)
                begin
                    res_valid           = 1'b1;
                    res_data.out_byte   = have_reg ? val_reg : 8'd0;
                    res_data.out_repeat = have_reg ? rep_reg : '0;
                    res_data.out_last   = 1'b1;
                    res_data.status     = end_fin;
                end
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            phase_reg  <= PH_IDLE;
            flag_reg   <= '0;
            ftb_reg    <= '0;
            finish_reg <= ST_RUNNING;
            cnt_reg    <= '0;
            have_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            flag_reg   <= flag_next;
            ftb_reg    <= ftb_next;
            finish_reg <= finish_next;
            cnt_reg    <= cnt_next;
            have_reg   <= have_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
        val_reg  <= val_next;
        rep_reg  <= rep_next;
        rem_reg  <= rem_next;
        off_reg  <= off_next;
    end

`ifndef SYNTHESIS
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> out_free)
        else $error("result produced while the output register is occupied");

    a_finish_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (finish_reg != ST_RUNNING) |=> (finish_reg != ST_RUNNING))
        else $error("finished status was cleared");

    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (cnt_reg >= $past(cnt_reg)))
        else $error("output count went backwards");

    a_copy_remaining: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD) |-> (rem_reg != '0))
        else $error("history read issued with no copy bytes left");
`endif

endmodule
